[design/aarm_pkg.sv]
package aarm_pkg;

  localparam int OUT_FRAC_BITS_DEF = 30;
  localparam int CORDIC_STEPS_DEF  = 24;
  localparam int CORDIC_STEPS_MAX  = 32;

  // Register stages of the axis normalizer and of the matrix stage.
  localparam int NORM_LAT = 69;
  localparam int MAT_LAT  = 4;

  localparam logic [29:0] THR_RESET = 30'd10737;

  // Shift-and-subtract divide, used only to build constants at elaboration.
  function automatic logic [63:0] udiv64(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[63:0], a[i]};
      if (r >= {1'b0, b}) begin
        r = r - {1'b0, b};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // Alternating arctangent series in Q62; x = p0 / 2^62 and x^2 = 1/d.
  function automatic logic [63:0] atan_series(input logic [63:0] p0, input logic [63:0] d);
    logic [63:0] p;
    logic [63:0] sum;
    logic [63:0] n;
    logic [63:0] term;
    logic        add;
    p   = p0;
    sum = '0;
    n   = 64'd1;
    add = 1'b1;
    for (int j = 0; j < 96; j++) begin
      if (p != '0) begin
        term = udiv64(p, n);
        sum  = add ? sum + term : sum - term;
        add  = !add;
        n    = n + 64'd2;
        p    = udiv64(p, d);
      end
    end
    return sum;
  endfunction

  // pi/4 in Q62 by Machin's formula.
  function automatic logic [63:0] pi4_q62();
    logic [63:0] a5;
    logic [63:0] a239;
    a5   = atan_series(udiv64(64'd1 << 62, 64'd5), 64'd25);
    a239 = atan_series(udiv64(64'd1 << 62, 64'd239), 64'd57121);
    return (a5 << 2) - a239;
  endfunction

  // Arctangent of 2^-i in Q60.
  function automatic logic [63:0] aarm_atan(input int i);
    logic [63:0] a62;
    if (i == 0) begin
      a62 = pi4_q62();
    end else begin
      a62 = atan_series(64'd1 << (62 - i), 64'd1 << (2 * i));
    end
    return (a62 + 64'd2) >> 2;
  endfunction

  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] n;
    logic [63:0] res;
    logic [63:0] bitv;
    n    = v;
    res  = '0;
    bitv = 64'd1 << 62;
    for (int j = 0; j < 32; j++) begin
      if (bitv > n) bitv = bitv >> 2;
    end
    for (int j = 0; j < 32; j++) begin
      if (bitv != '0) begin
        if (n >= res + bitv) begin
          n   = n - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
    end
    return res;
  endfunction

  // Inverse CORDIC gain in Q32 for the given step count.
  function automatic logic [63:0] cordic_k32(input int steps);
    logic [63:0] gain;
    logic [63:0] sq;
    gain = 64'd1 << 61;
    for (int i = 0; i < CORDIC_STEPS_MAX; i++) begin
      if (i < steps) gain = gain + (gain >> (2 * i));
    end
    sq = isqrt64(gain >> 1);
    return udiv64((64'd1 << 62) + (sq >> 1), sq);
  endfunction

  // Degrees (Q16) to radians (Q60) scale: round(pi * 2^44 / 180).
  function automatic logic [63:0] rad_scale();
    return udiv64((pi4_q62() >> 16) + 64'd90, 64'd180);
  endfunction

  // Product of two Q2.30 values rounded back to Q2.30, ties toward plus infinity.
  function automatic logic signed [35:0] rnd30(input logic signed [65:0] p);
    logic signed [65:0] r;
    r = (p + (66'sd1 <<< 29)) >>> 30;
    return r[35:0];
  endfunction

endpackage

[design/aarm_norm.sv]
module aarm_norm import aarm_pkg::*; (
  input  logic               clk,
  input  logic               en,
  input  logic signed [31:0] ax,
  input  logic signed [31:0] ay,
  input  logic signed [31:0] az,
  output logic signed [31:0] ux,
  output logic signed [31:0] uy,
  output logic signed [31:0] uz,
  output logic               zero
);

  typedef struct packed {
    logic [63:0]      rem;
    logic [63:0]      res;
    logic [2:0][31:0] am;
    logic [2:0]       neg;
    logic [4:0]       k;
    logic             zero;
  } rt_stage_t;

  typedef struct packed {
    logic [31:0]      mag;
    logic [2:0][32:0] r;
    logic [2:0][30:0] lo;
    logic [2:0][30:0] q;
    logic [2:0]       neg;
    logic             zero;
  } dv_stage_t;

  logic signed [31:0] a_in [3];
  logic signed [31:0] a1_r [3];
  logic signed [31:0] a2_r [3];
  logic signed [31:0] a3_r [3];
  logic [63:0]        sq1_r [3];
  logic [63:0]        sq1_nxt [3];
  logic [63:0]        s2_r;
  logic [63:0]        s3_r;
  logic [4:0]         k3_r;
  logic               zero3_r;
  logic [5:0]         msb;
  logic [5:0]         lz;
  rt_stage_t          rt_r [33];
  rt_stage_t          rt0_nxt;
  dv_stage_t          dv_r [32];
  dv_stage_t          dv0_nxt;
  logic signed [31:0] u_r [3];
  logic               zero_r;

  assign a_in[0] = ax;
  assign a_in[1] = ay;
  assign a_in[2] = az;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sq1_nxt[i] = 64'(a_in[i]) * 64'(a_in[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        a1_r[i]  <= a_in[i];
        sq1_r[i] <= sq1_nxt[i];
        a2_r[i]  <= a1_r[i];
        a3_r[i]  <= a2_r[i];
      end
      s2_r <= sq1_r[0] + sq1_r[1] + sq1_r[2];
    end
  end

  always_comb begin
    msb = '0;
    for (int i = 0; i < 64; i++) begin
      if (s2_r[i]) msb = 6'(i);
    end
    lz = 6'd63 - msb;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_r    <= s2_r;
      k3_r    <= lz[5:1];
      zero3_r <= (s2_r == '0);
    end
  end

  // Shifting by an even amount leaves the top two bits nonzero, so the
  // square root always takes all 32 steps.
  always_comb begin
    rt0_nxt      = '0;
    rt0_nxt.rem  = s3_r << {k3_r, 1'b0};
    rt0_nxt.k    = k3_r;
    rt0_nxt.zero = zero3_r;
    for (int i = 0; i < 3; i++) begin
      rt0_nxt.neg[i] = a3_r[i][31];
      rt0_nxt.am[i]  = a3_r[i][31] ? 32'(-a3_r[i]) : 32'(a3_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) rt_r[0] <= rt0_nxt;
  end

  for (genvar j = 0; j < 32; j++) begin : g_sqrt
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * j);
    rt_stage_t st_nxt;
    always_comb begin
      st_nxt = rt_r[j];
      if (rt_r[j].rem >= rt_r[j].res + BIT) begin
        st_nxt.rem = rt_r[j].rem - (rt_r[j].res + BIT);
        st_nxt.res = (rt_r[j].res >> 1) + BIT;
      end else begin
        st_nxt.res = rt_r[j].res >> 1;
      end
    end
    always_ff @(posedge clk) begin
      if (en) rt_r[j+1] <= st_nxt;
    end
  end

  // Dividend carries half the divisor so the quotient comes out rounded.
  always_comb begin
    logic [63:0] dnd;
    dv0_nxt      = '0;
    dv0_nxt.mag  = rt_r[32].res[31:0];
    dv0_nxt.neg  = rt_r[32].neg;
    dv0_nxt.zero = rt_r[32].zero;
    for (int i = 0; i < 3; i++) begin
      dnd           = ((64'(rt_r[32].am[i]) << rt_r[32].k) << 30)
                      + 64'(rt_r[32].res[31:1]);
      dv0_nxt.r[i]  = dnd[63:31];
      dv0_nxt.lo[i] = dnd[30:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) dv_r[0] <= dv0_nxt;
  end

  for (genvar j = 0; j < 31; j++) begin : g_div
    dv_stage_t st_nxt;
    always_comb begin
      logic [32:0] r2;
      st_nxt = dv_r[j];
      for (int i = 0; i < 3; i++) begin
        r2 = {dv_r[j].r[i][31:0], dv_r[j].lo[i][30-j]};
        if (r2 >= {1'b0, dv_r[j].mag}) begin
          st_nxt.r[i] = r2 - {1'b0, dv_r[j].mag};
          st_nxt.q[i] = {dv_r[j].q[i][29:0], 1'b1};
        end else begin
          st_nxt.r[i] = r2;
          st_nxt.q[i] = {dv_r[j].q[i][29:0], 1'b0};
        end
      end
    end
    always_ff @(posedge clk) begin
      if (en) dv_r[j+1] <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        u_r[i] <= dv_r[31].neg[i] ? -signed'(32'(dv_r[31].q[i]))
                                  : signed'(32'(dv_r[31].q[i]));
      end
      zero_r <= dv_r[31].zero;
    end
  end

  assign ux   = u_r[0];
  assign uy   = u_r[1];
  assign uz   = u_r[2];
  assign zero = zero_r;

endmodule

[design/aarm_cordic.sv]
module aarm_cordic import aarm_pkg::*; #(
  parameter int STEPS = CORDIC_STEPS_DEF,
  parameter int PAD   = NORM_LAT - CORDIC_STEPS_DEF - 2
) (
  input  logic               clk,
  input  logic               en,
  input  logic signed [25:0] angle,
  output logic signed [31:0] cos_q30,
  output logic signed [31:0] sin_q30,
  output logic signed [32:0] omc_q30
);

  localparam logic signed [26:0] HALF    = 27'sd11796480;
  localparam logic signed [26:0] FULL    = 27'sd23592960;
  localparam logic signed [26:0] QUARTER = 27'sd5898240;
  localparam logic signed [63:0] RAD_K   = signed'(rad_scale());
  localparam logic signed [43:0] X0      = signed'(44'(cordic_k32(STEPS) << 8));

  logic signed [43:0] x_r [STEPS+1];
  logic signed [43:0] y_r [STEPS+1];
  logic signed [63:0] z_r [STEPS+1];
  logic               flip_r [STEPS+1];
  logic signed [26:0] ang_red;
  logic               flip_nxt;
  logic signed [63:0] z_nxt;
  logic signed [43:0] xr;
  logic signed [43:0] yr;
  logic signed [31:0] c_nxt;
  logic signed [31:0] s_nxt;
  logic signed [31:0] c_dl_r [PAD+1];
  logic signed [31:0] s_dl_r [PAD+1];
  logic signed [32:0] t_dl_r [PAD+1];

  // Bring the angle into (-180,180], then into [-90,90]; the half-turn fold
  // negates both sine and cosine.
  always_comb begin
    ang_red  = 27'(angle);
    flip_nxt = 1'b0;
    if (ang_red > HALF) begin
      ang_red = ang_red - FULL;
    end else if (ang_red <= -HALF) begin
      ang_red = ang_red + FULL;
    end
    if (ang_red > QUARTER) begin
      ang_red  = ang_red - HALF;
      flip_nxt = 1'b1;
    end else if (ang_red < -QUARTER) begin
      ang_red  = ang_red + HALF;
      flip_nxt = 1'b1;
    end
    z_nxt = 64'(ang_red) * RAD_K;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0]    <= X0;
      y_r[0]    <= '0;
      z_r[0]    <= z_nxt;
      flip_r[0] <= flip_nxt;
    end
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    localparam logic signed [63:0] ATN = signed'(aarm_atan(i));
    always_ff @(posedge clk) begin
      if (en) begin
        if (z_r[i] >= 0) begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - ATN;
        end else begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + ATN;
        end
        flip_r[i+1] <= flip_r[i];
      end
    end
  end

  always_comb begin
    xr    = (x_r[STEPS] + 44'sd512) >>> 10;
    yr    = (y_r[STEPS] + 44'sd512) >>> 10;
    c_nxt = flip_r[STEPS] ? -32'(xr) : 32'(xr);
    s_nxt = flip_r[STEPS] ? -32'(yr) : 32'(yr);
  end

  // The delay line lines the angle results up with the axis normalizer.
  always_ff @(posedge clk) begin
    if (en) begin
      c_dl_r[0] <= c_nxt;
      s_dl_r[0] <= s_nxt;
      t_dl_r[0] <= 33'sd1073741824 - 33'(c_nxt);
      for (int j = 1; j <= PAD; j++) begin
        c_dl_r[j] <= c_dl_r[j-1];
        s_dl_r[j] <= s_dl_r[j-1];
        t_dl_r[j] <= t_dl_r[j-1];
      end
    end
  end

  assign cos_q30 = c_dl_r[PAD];
  assign sin_q30 = s_dl_r[PAD];
  assign omc_q30 = t_dl_r[PAD];

endmodule

[design/aarm_mat.sv]
module aarm_mat import aarm_pkg::*; #(
  parameter int OUT_FRAC_BITS = OUT_FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               en,
  input  logic signed [31:0] ux,
  input  logic signed [31:0] uy,
  input  logic signed [31:0] uz,
  input  logic               zero,
  input  logic signed [31:0] cos_q30,
  input  logic signed [31:0] sin_q30,
  input  logic signed [32:0] omc_q30,
  input  logic [29:0]        thr,
  output logic signed [31:0] m [9],
  output logic               axis_zero
);

  localparam int                 SH   = 30 - OUT_FRAC_BITS;
  localparam logic signed [35:0] RND  = (36'sd1 <<< SH) >>> 1;
  localparam logic signed [35:0] MAXV = 36'sd2147483647;
  localparam logic signed [35:0] MINV = -36'sd2147483648;

  // Pair order: xx, xy, xz, yy, yz, zz.
  logic signed [31:0] p_r [6];
  logic signed [31:0] s1_r [3];
  logic signed [31:0] c1_r;
  logic signed [32:0] t1_r;
  logic               z1_r;
  logic signed [32:0] q_r [6];
  logic signed [31:0] s2_r [3];
  logic signed [31:0] c2_r;
  logic               z2_r;
  logic signed [34:0] e_r [9];
  logic               z3_r;
  logic signed [31:0] m_r [9];
  logic               zero_r;
  logic signed [31:0] m_nxt [9];

  always_ff @(posedge clk) begin
    if (en) begin
      p_r[0]  <= 32'(rnd30(66'(ux) * 66'(ux)));
      p_r[1]  <= 32'(rnd30(66'(ux) * 66'(uy)));
      p_r[2]  <= 32'(rnd30(66'(ux) * 66'(uz)));
      p_r[3]  <= 32'(rnd30(66'(uy) * 66'(uy)));
      p_r[4]  <= 32'(rnd30(66'(uy) * 66'(uz)));
      p_r[5]  <= 32'(rnd30(66'(uz) * 66'(uz)));
      s1_r[0] <= 32'(rnd30(66'(ux) * 66'(sin_q30)));
      s1_r[1] <= 32'(rnd30(66'(uy) * 66'(sin_q30)));
      s1_r[2] <= 32'(rnd30(66'(uz) * 66'(sin_q30)));
      c1_r    <= cos_q30;
      t1_r    <= omc_q30;
      z1_r    <= zero;

      for (int i = 0; i < 6; i++) begin
        q_r[i] <= 33'(rnd30(66'(p_r[i]) * 66'(t1_r)));
      end
      for (int i = 0; i < 3; i++) begin
        s2_r[i] <= s1_r[i];
      end
      c2_r <= c1_r;
      z2_r <= z1_r;

      e_r[0] <= 35'(c2_r) + 35'(q_r[0]);
      e_r[1] <= 35'(q_r[1]) - 35'(s2_r[2]);
      e_r[2] <= 35'(q_r[2]) + 35'(s2_r[1]);
      e_r[3] <= 35'(q_r[1]) + 35'(s2_r[2]);
      e_r[4] <= 35'(c2_r) + 35'(q_r[3]);
      e_r[5] <= 35'(q_r[4]) - 35'(s2_r[0]);
      e_r[6] <= 35'(q_r[2]) - 35'(s2_r[1]);
      e_r[7] <= 35'(q_r[4]) + 35'(s2_r[0]);
      e_r[8] <= 35'(c2_r) + 35'(q_r[5]);
      z3_r   <= z2_r;

      for (int i = 0; i < 9; i++) begin
        m_r[i] <= m_nxt[i];
      end
      zero_r <= z3_r;
    end
  end

  // Flush small positive entries, round to the output format, saturate; a zero axis gives an all-zero matrix.
  always_comb begin
    logic signed [35:0] v;
    for (int i = 0; i < 9; i++) begin
      v = 36'(e_r[i]);
      if (v > 0 && v <= signed'(36'(thr))) v = '0;
      v = (v + RND) >>> SH;
      if (v > MAXV) v = MAXV;
      if (v < MINV) v = MINV;
      m_nxt[i] = z3_r ? '0 : 32'(v);
    end
  end

  assign m         = m_r;
  assign axis_zero = zero_r;

endmodule

[design/axis_angle_rotation_matrix_top.sv]
// Accepted inputs go through the axis normalizer and the matrix stage to out_*.
// Throughput: one transaction per cycle unless out_stall holds a result; the
// 32-step square root and 31-step divider of the axis normalizer set the depth.
// A stalled result freezes the whole pipeline until it is taken.
// Reset clears all valid bits and sets the flush threshold (thr_r) to 10737.
module axis_angle_rotation_matrix_top import aarm_pkg::*; #(
  parameter int OUT_FRAC_BITS = OUT_FRAC_BITS_DEF,
  parameter int CORDIC_STEPS  = CORDIC_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_axis_x,
  input  logic signed [31:0] in_axis_y,
  input  logic signed [31:0] in_axis_z,
  input  logic signed [25:0] in_angle_degrees,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_m00,
  output logic signed [31:0] out_m01,
  output logic signed [31:0] out_m02,
  output logic signed [31:0] out_m10,
  output logic signed [31:0] out_m11,
  output logic signed [31:0] out_m12,
  output logic signed [31:0] out_m20,
  output logic signed [31:0] out_m21,
  output logic signed [31:0] out_m22,
  output logic               out_axis_zero,
  input  logic               cfg_wen,
  input  logic [29:0]        cfg_wdata
);

  localparam int LAT = NORM_LAT + MAT_LAT;

  logic [LAT-1:0]     vld_r;
  logic [29:0]        thr_r;
  logic               en;
  logic signed [31:0] ux;
  logic signed [31:0] uy;
  logic signed [31:0] uz;
  logic               zero;
  logic signed [31:0] cos_q30;
  logic signed [31:0] sin_q30;
  logic signed [32:0] omc_q30;
  logic signed [31:0] m [9];

  assign en        = !(vld_r[LAT-1] && out_stall);
  assign in_stall  = !en;
  assign out_valid = vld_r[LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      thr_r <= THR_RESET;
    end else begin
      if (en) vld_r <= {vld_r[LAT-2:0], in_valid};
      if (cfg_wen) thr_r <= cfg_wdata;
    end
  end

  aarm_norm u_norm (
    .clk  (clk),
    .en   (en),
    .ax   (in_axis_x),
    .ay   (in_axis_y),
    .az   (in_axis_z),
    .ux   (ux),
    .uy   (uy),
    .uz   (uz),
    .zero (zero)
  );

  aarm_cordic #(
    .STEPS (CORDIC_STEPS),
    .PAD   (NORM_LAT - CORDIC_STEPS - 2)
  ) u_cordic (
    .clk     (clk),
    .en      (en),
    .angle   (in_angle_degrees),
    .cos_q30 (cos_q30),
    .sin_q30 (sin_q30),
    .omc_q30 (omc_q30)
  );

  aarm_mat #(
    .OUT_FRAC_BITS (OUT_FRAC_BITS)
  ) u_mat (
    .clk       (clk),
    .en        (en),
    .ux        (ux),
    .uy        (uy),
    .uz        (uz),
    .zero      (zero),
    .cos_q30   (cos_q30),
    .sin_q30   (sin_q30),
    .omc_q30   (omc_q30),
    .thr       (thr_r),
    .m         (m),
    .axis_zero (out_axis_zero)
  );

  assign out_m00 = m[0];
  assign out_m01 = m[1];
  assign out_m02 = m[2];
  assign out_m10 = m[3];
  assign out_m11 = m[4];
  assign out_m12 = m[5];
  assign out_m20 = m[6];
  assign out_m21 = m[7];
  assign out_m22 = m[8];

endmodule

[bench/tb_axis_angle_rotation_matrix_top.sv]
module tb_axis_angle_rotation_matrix_top;
  import aarm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STEPS     = CORDIC_STEPS_DEF;
  localparam int RAND_ITEMS = 1800;
  localparam int DRAIN_WAIT = NORM_LAT + MAT_LAT + 10;

  typedef struct packed {
    logic [8:0][31:0] m;
    logic             axis_zero;
  } matrix_t;

  typedef struct {
    logic signed [31:0] ax;
    logic signed [31:0] ay;
    logic signed [31:0] az;
    logic signed [25:0] ang;
    bit                 typed;
    matrix_t            want;
  } row_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic signed [31:0] in_axis_x;
  logic signed [31:0] in_axis_y;
  logic signed [31:0] in_axis_z;
  logic signed [25:0] in_angle_degrees;
  logic               out_valid;
  logic               out_stall;
  logic signed [31:0] out_m00, out_m01, out_m02;
  logic signed [31:0] out_m10, out_m11, out_m12;
  logic signed [31:0] out_m20, out_m21, out_m22;
  logic               out_axis_zero;
  logic               cfg_wen;
  logic [29:0]        cfg_wdata;

  longint unsigned atan_tab[STEPS];
  longint          k32_start;
  longint          deg_to_rad;
  logic [29:0]     flush_thr;

  matrix_t matrices_due[$];
  bit      typed_flags[$];
  matrix_t typed_matrices[$];
  int      errors;
  int      n_checked;
  int      n_zero_axis;
  bit      hold_req;
  bit      quiet_sender;

  axis_angle_rotation_matrix_top u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_axis_x(in_axis_x), .in_axis_y(in_axis_y), .in_axis_z(in_axis_z),
    .in_angle_degrees(in_angle_degrees),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_m00(out_m00), .out_m01(out_m01), .out_m02(out_m02),
    .out_m10(out_m10), .out_m11(out_m11), .out_m12(out_m12),
    .out_m20(out_m20), .out_m21(out_m21), .out_m22(out_m22),
    .out_axis_zero(out_axis_zero),
    .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic longint unsigned arctan_sum(longint unsigned p0, longint unsigned d);
    longint unsigned p, sum, n;
    bit add;
    p = p0;
    sum = 0;
    n = 1;
    add = 1'b1;
    while (p != 0) begin
      sum = add ? sum + p / n : sum - p / n;
      add = !add;
      n += 2;
      p = p / d;
    end
    return sum;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned n, res, b;
    n = v;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic void build_cordic_constants();
    longint unsigned pi4, gain, sq, a62;
    pi4 = 4 * arctan_sum((64'd1 << 62) / 5, 25) - arctan_sum((64'd1 << 62) / 239, 57121);
    gain = 64'd1 << 61;
    for (int i = 0; i < STEPS; i++) begin
      a62 = (i == 0) ? pi4 : arctan_sum(64'd1 << (62 - i), 64'd1 << (2 * i));
      atan_tab[i] = (a62 + 2) >> 2;
      gain += gain >> (2 * i);
    end
    sq = int_sqrt(gain >> 1);
    k32_start = longint'(((64'd1 << 62) + sq / 2) / sq);
    deg_to_rad = longint'(((pi4 >> 16) + 90) / 180);
  endfunction

  function automatic longint round_shift(longint v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint mul_q30(longint a, longint b);
    return round_shift(a * b, 30);
  endfunction

  function automatic longint unit_component(longint a, int k, longint unsigned mag);
    longint unsigned num;
    longint q;
    num = (longint'(a < 0 ? -a : a) << k) << 30;
    q = longint'((num + mag / 2) / mag);
    return a < 0 ? -q : q;
  endfunction

  function automatic logic [31:0] flush_entry(longint v, logic [29:0] thr);
    if (v > 0 && v <= longint'(thr)) v = 0;
    if (OUT_FRAC_BITS_DEF < 30) v = round_shift(v, 30 - OUT_FRAC_BITS_DEF);
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[31:0];
  endfunction

  function automatic matrix_t rotation_matrix(logic signed [31:0] ax32, logic signed [31:0] ay32,
                                              logic signed [31:0] az32,
                                              logic signed [25:0] ang26, logic [29:0] thr);
    longint ax, ay, az, a, x, y, z, dx, dy, c, sn, t, ux, uy, uz;
    longint mm[9];
    longint unsigned s, mag;
    int lz, k;
    bit flip;
    matrix_t r;
    ax = ax32;
    ay = ay32;
    az = az32;
    a = ang26;
    flip = 1'b0;
    if (a > (64'sd180 <<< 16)) a -= 64'sd360 <<< 16;
    else if (a <= -(64'sd180 <<< 16)) a += 64'sd360 <<< 16;
    if (a > (64'sd90 <<< 16)) begin
      a -= 64'sd180 <<< 16;
      flip = 1'b1;
    end else if (a < -(64'sd90 <<< 16)) begin
      a += 64'sd180 <<< 16;
      flip = 1'b1;
    end
    z = a * deg_to_rad;
    x = k32_start <<< 8;
    y = 0;
    for (int i = 0; i < STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx;
        y += dy;
        z -= longint'(atan_tab[i]);
      end else begin
        x += dx;
        y -= dy;
        z += longint'(atan_tab[i]);
      end
    end
    c = round_shift(x, 10);
    sn = round_shift(y, 10);
    if (flip) begin
      c = -c;
      sn = -sn;
    end
    t = (64'sd1 <<< 30) - c;
    r = '0;
    s = longint'(ax * ax) + longint'(ay * ay) + longint'(az * az);
    if (s == 0) begin
      r.axis_zero = 1'b1;
      return r;
    end
    lz = 0;
    while (((s << lz) >> 63) == 0) lz++;
    k = lz / 2;
    mag = int_sqrt(s << (2 * k));
    ux = unit_component(ax, k, mag);
    uy = unit_component(ay, k, mag);
    uz = unit_component(az, k, mag);
    mm[0] = c + mul_q30(mul_q30(ux, ux), t);
    mm[1] = mul_q30(mul_q30(ux, uy), t) - mul_q30(uz, sn);
    mm[2] = mul_q30(mul_q30(ux, uz), t) + mul_q30(uy, sn);
    mm[3] = mul_q30(mul_q30(uy, ux), t) + mul_q30(uz, sn);
    mm[4] = c + mul_q30(mul_q30(uy, uy), t);
    mm[5] = mul_q30(mul_q30(uy, uz), t) - mul_q30(ux, sn);
    mm[6] = mul_q30(mul_q30(uz, ux), t) - mul_q30(uy, sn);
    mm[7] = mul_q30(mul_q30(uz, uy), t) + mul_q30(ux, sn);
    mm[8] = c + mul_q30(mul_q30(uz, uz), t);
    for (int i = 0; i < 9; i++) r.m[i] = flush_entry(mm[i], thr);
    return r;
  endfunction

  // Predict at the accepting edge; inputs and flush_thr are stable there.
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      if (typed_flags.size() > 0 && typed_flags.pop_front()) begin
        matrices_due.push_back(typed_matrices.pop_front());
      end else begin
        matrices_due.push_back(rotation_matrix(in_axis_x, in_axis_y, in_axis_z,
                                               in_angle_degrees, flush_thr));
      end
    end
  end

  always @(posedge clk) begin
    matrix_t got, want;
    if (rst_n && out_valid && !out_stall) begin
      got.m = {out_m22, out_m21, out_m20, out_m12, out_m11, out_m10, out_m02, out_m01, out_m00};
      got.axis_zero = out_axis_zero;
      if (matrices_due.size() == 0) begin
        errors++;
        $display("%0t: result transaction with nothing expected", $realtime);
      end else begin
        want = matrices_due.pop_front();
        n_checked++;
        if (got.axis_zero) n_zero_axis++;
        for (int i = 0; i < 9; i++) begin
          if (got.m[i] !== want.m[i]) begin
            errors++;
            $display("%0t: m%0d%0d expected %h got %h", $realtime, i / 3, i % 3,
                     want.m[i], got.m[i]);
          end
        end
        if (got.axis_zero !== want.axis_zero) begin
          errors++;
          $display("%0t: axis_zero expected %b got %b", $realtime, want.axis_zero,
                   got.axis_zero);
        end
      end
    end
  end

  // Result side back-pressure: mostly short random stalls, now and then a long one,
  // and a single very long hold-off on request.
  initial begin
    int r, len;
    out_stall <= 1'b0;
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (300) @(posedge clk);
      end else begin
        r = $urandom_range(0, 99);
        out_stall <= quiet_sender ? 1'b0 : (r < 25);
        len = (r < 3) ? $urandom_range(20, 60) : $urandom_range(1, 4);
        repeat (len) @(posedge clk);
      end
    end
  end

  task automatic send(row_t rw);
    int g;
    typed_flags.push_back(rw.typed);
    if (rw.typed) typed_matrices.push_back(rw.want);
    in_valid <= 1'b1;
    in_axis_x <= rw.ax;
    in_axis_y <= rw.ay;
    in_axis_z <= rw.az;
    in_angle_degrees <= rw.ang;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (!quiet_sender) begin
      g = $urandom_range(0, 99);
      g = (g < 70) ? 0 : (g < 97) ? $urandom_range(1, 3) : $urandom_range(15, 50);
      if (g > 0) begin
        in_valid <= 1'b0;
        repeat (g) @(posedge clk);
      end
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    wait (matrices_due.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic set_threshold(logic [29:0] v);
    @(posedge clk);
    cfg_wen <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_wen <= 1'b0;
    flush_thr = v;
  endtask

  function automatic logic signed [31:0] random_component();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return $urandom;
    if (r < 75) return $signed($urandom) >>> $urandom_range(8, 31);
    if (r < 85) return 32'sd0;
    if (r < 92) return (r & 1) ? 32'sh7FFFFFFF : 32'sh80000000;
    return 32'sd65536;
  endfunction

  function automatic row_t random_row();
    row_t rw;
    int r;
    rw.typed = 1'b0;
    rw.want = '0;
    r = $urandom_range(0, 99);
    if (r < 5) begin
      rw.ax = 0;
      rw.ay = 0;
      rw.az = 0;
    end else begin
      rw.ax = random_component();
      rw.ay = random_component();
      rw.az = random_component();
    end
    r = $urandom_range(0, 99);
    if (r < 70) rw.ang = 26'(int'($urandom_range(0, 47185920)) - 23592960);
    else if (r < 85) rw.ang = 26'($urandom);
    else rw.ang = 26'((int'($urandom_range(0, 8)) - 4) * (90 <<< 16));
    return rw;
  endfunction

  function automatic row_t mk(logic signed [31:0] x, logic signed [31:0] y,
                              logic signed [31:0] z, logic signed [25:0] a, bit zero_axis);
    row_t rw;
    rw.ax = x;
    rw.ay = y;
    rw.az = z;
    rw.ang = a;
    rw.typed = zero_axis;
    rw.want = '0;
    rw.want.axis_zero = zero_axis;
    return rw;
  endfunction

  initial begin
    row_t directed[$];
    logic [29:0] thr_plan[4];
    build_cordic_constants();
    errors = 0;
    n_checked = 0;
    n_zero_axis = 0;
    hold_req = 1'b0;
    quiet_sender = 1'b0;
    flush_thr = THR_RESET;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_axis_x <= '0;
    in_axis_y <= '0;
    in_axis_z <= '0;
    in_angle_degrees <= '0;
    cfg_wen <= 1'b0;
    cfg_wdata <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Zero axis rows have their result typed in; the rest go through the predictor.
    directed = '{
      mk(0, 0, 0, 0, 1),
      mk(0, 0, 0, 26'sd23592960, 1),
      mk(0, 0, 0, -26'sd23592960, 1),
      mk(0, 0, 0, 26'sh1FFFFFF, 1),
      mk(0, 0, 0, 26'sh2000000, 1),
      mk(32'sd65536, 0, 0, 0, 0),
      mk(0, 32'sd65536, 0, 26'sd90 <<< 16, 0),
      mk(0, 0, 32'sd65536, 26'sd180 <<< 16, 0),
      mk(0, 0, -32'sd65536, -26'sd180 <<< 16, 0),
      mk(32'sd65536, 32'sd65536, 0, -26'sd90 <<< 16, 0),
      mk(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 26'sd45 <<< 16, 0),
      mk(32'sh80000000, 32'sh80000000, 32'sh80000000, 26'sd270 <<< 16, 0),
      mk(32'sh80000000, 0, 0, 26'sd23592960, 0),
      mk(1, 1, 1, 26'sd30 <<< 16, 0),
      mk(1, 0, 0, -26'sd23592960, 0),
      mk(0, 0, -1, 26'sh1FFFFFF, 0),
      mk(32'sd3, -32'sd4, 32'sd12, 26'sh2000000, 0),
      mk(32'sh12345678, -32'sh0FEDCBA9, 32'sh00ABCDEF, 26'sd1, 0),
      mk(-32'sd65536, 32'sd131072, 32'sd196608, -26'sd1, 0),
      mk(32'sh7FFFFFFF, 32'sh80000000, 0, 26'sd360 <<< 16, 0)
    };
    foreach (directed[i]) send(directed[i]);
    settle();

    thr_plan = '{30'd0, 30'h3FFFFFFF, 30'($urandom), THR_RESET};
    for (int p = 0; p < 4; p++) begin
      set_threshold(thr_plan[p]);
      for (int i = 0; i < RAND_ITEMS / 4; i++) begin
        if (p == 1 && i == 50) hold_req = 1'b1;
        // A stretch of back-to-back traffic with no idling on either side.
        quiet_sender = (i >= 200 && i < 260);
        send(random_row());
      end
      quiet_sender = 1'b0;
      settle();
    end

    $display("Checked %0d result transactions (%0d with a zero axis) over five flush settings,",
             n_checked, n_zero_axis);
    $display("including a long output hold-off that backed up the input.");
    if (errors == 0) begin
      $display("tb_axis_angle_rotation_matrix_top: PASS");
    end else begin
      $display("tb_axis_angle_rotation_matrix_top: FAIL");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Timed out with %0d results outstanding.", matrices_due.size());
    $display("tb_axis_angle_rotation_matrix_top: FAIL");
    $finish;
  end

endmodule
